>>> design/lsap_pkg.sv
`default_nettype none

package lsap_pkg;

  // Body layout
  localparam logic [2:0]  FIXED_PART_BYTES = 3'd4;
  localparam logic [2:0]  FP_FLAGS         = 3'd0;
  localparam logic [2:0]  FP_COUNT_HI      = 3'd2;
  localparam logic [2:0]  FP_COUNT_LO      = 3'd3;

  localparam logic [10:0] LINK_DATA_OFS    = 11'd4;
  localparam logic [10:0] LINK_TYPE_OFS    = 11'd8;
  localparam logic [10:0] LINK_TOS_OFS     = 11'd9;
  localparam logic [10:0] LINK_METRIC_END  = 11'd12;
  localparam logic [11:0] LINK_FIXED_BYTES = 12'd12;

  // Link types that are legal
  localparam logic [7:0]  LINK_TYPE_MIN    = 8'd1;
  localparam logic [7:0]  LINK_TYPE_MAX    = 8'd4;

  // Verdict codes
  localparam logic [2:0]  ST_OK        = 3'd0;
  localparam logic [2:0]  ST_SHORT     = 3'd1;
  localparam logic [2:0]  ST_BAD_TYPE  = 3'd2;
  localparam logic [2:0]  ST_TRUNCATED = 3'd3;
  localparam logic [2:0]  ST_MISSING   = 3'd4;
  localparam logic [2:0]  ST_TRAILING  = 3'd5;

  // Result kinds
  localparam logic KIND_LINK    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Result queue depth (at least two)
  localparam int unsigned OQ_DEPTH = 4;

  typedef struct packed {
    logic        kind;
    logic [15:0] link_index;
    logic [31:0] link_id;
    logic [31:0] link_info;
    logic [2:0]  link_type;
    logic [15:0] metric;
    logic [7:0]  tos_skipped;
    logic [2:0]  router_flags;
    logic [15:0] declared_links;
    logic [2:0]  status;
    logic        last_result;
  } result_t;

  // Results pushed by the parser in one cycle: record first, verdict second
  typedef struct packed {
    logic rec_valid;
    logic vrd_valid;
  } push_t;

endpackage

`default_nettype wire

>>> design/lsap_byte_if.sv
`default_nettype none

interface lsap_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       last;

  modport source (output valid, output body_byte, output last, input ready);
  modport sink   (input valid, input body_byte, input last, output ready);
endinterface

`default_nettype wire

>>> design/lsap_result_if.sv
`default_nettype none

interface lsap_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] link_index;
  logic [31:0] link_id;
  logic [31:0] link_info;
  logic [2:0]  link_type;
  logic [15:0] metric;
  logic [7:0]  tos_skipped;
  logic [2:0]  router_flags;
  logic [15:0] declared_links;
  logic [2:0]  status;
  logic        last_result;

  modport source (
    output valid, output kind, output link_index, output link_id, output link_info,
    output link_type, output metric, output tos_skipped, output router_flags,
    output declared_links, output status, output last_result, input ready
  );
  modport sink (
    input valid, input kind, input link_index, input link_id, input link_info,
    input link_type, input metric, input tos_skipped, input router_flags,
    input declared_links, input status, input last_result, output ready
  );
endinterface

`default_nettype wire

>>> design/lsap_parse.sv
`default_nettype none

// Input word register plus the per-byte parse step. Produces up to two
// results per byte (link record, then verdict) for the result queue.
module lsap_parse (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  output logic                   in_ready,
  input  wire logic              room,
  output lsap_pkg::push_t        push,
  output lsap_pkg::result_t      rec,
  output lsap_pkg::result_t      vrd
);

  // Input stage
  logic       stg_valid;
  logic [7:0] stg_byte;
  logic       stg_last;
  logic       take;

  // Parse state
  logic [2:0]  fixed_position, fixed_position_next;
  logic [2:0]  flags_reg, flags_reg_next;
  logic [15:0] declared_count, declared_count_next;
  logic [15:0] links_done, links_done_next;
  logic [10:0] link_position, link_position_next;
  logic [7:0]  tos_entries, tos_entries_next;
  logic [31:0] id_word, id_word_next;
  logic [31:0] data_word, data_word_next;
  logic [7:0]  type_byte, type_byte_next;
  logic [15:0] metric_acc, metric_acc_next;
  logic [2:0]  error_code, error_code_next;

  logic [11:0] pos_inc;
  logic [11:0] link_size;
  logic        rec_fire;
  logic [2:0]  verdict;

  assign take     = stg_valid && room;
  assign in_ready = !stg_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
    if (in_ready) begin
      stg_byte <= in_byte;
      stg_last <= in_last;
    end
  end

  // Next state for one body byte
  always_comb begin
    fixed_position_next = fixed_position;
    flags_reg_next      = flags_reg;
    declared_count_next = declared_count;
    links_done_next     = links_done;
    link_position_next  = link_position;
    tos_entries_next    = tos_entries;
    id_word_next        = id_word;
    data_word_next      = data_word;
    type_byte_next      = type_byte;
    metric_acc_next     = metric_acc;
    error_code_next     = error_code;
    rec_fire            = 1'b0;
    pos_inc             = {1'b0, link_position} + 12'd1;
    link_size           = '0;

    if (error_code == lsap_pkg::ST_OK) begin
      if (fixed_position < lsap_pkg::FIXED_PART_BYTES) begin
        case (fixed_position)
          lsap_pkg::FP_FLAGS:    flags_reg_next = stg_byte[2:0];
          lsap_pkg::FP_COUNT_HI: declared_count_next = {stg_byte, 8'h00};
          lsap_pkg::FP_COUNT_LO: declared_count_next = {declared_count[15:8], stg_byte};
          default: ;
        endcase
        fixed_position_next = fixed_position + 3'd1;
      end else if (links_done >= declared_count) begin
        error_code_next = lsap_pkg::ST_TRAILING;
      end else begin
        // Field capture by offset within the link
        if (link_position < lsap_pkg::LINK_DATA_OFS) begin
          id_word_next = {id_word[23:0], stg_byte};
        end else if (link_position < lsap_pkg::LINK_TYPE_OFS) begin
          data_word_next = {data_word[23:0], stg_byte};
        end else if (link_position == lsap_pkg::LINK_TYPE_OFS) begin
          type_byte_next = stg_byte;
          if (!(stg_byte inside {[lsap_pkg::LINK_TYPE_MIN:lsap_pkg::LINK_TYPE_MAX]})) begin
            error_code_next = lsap_pkg::ST_BAD_TYPE;
          end
        end else if (link_position == lsap_pkg::LINK_TOS_OFS) begin
          tos_entries_next = stg_byte;
        end else if (link_position < lsap_pkg::LINK_METRIC_END) begin
          metric_acc_next = {metric_acc[7:0], stg_byte};
        end

        // End of link: fixed part plus four bytes per TOS entry
        link_size = lsap_pkg::LINK_FIXED_BYTES + {2'b00, tos_entries_next, 2'b00};
        if (error_code_next == lsap_pkg::ST_OK) begin
          if (pos_inc >= lsap_pkg::LINK_FIXED_BYTES && pos_inc >= link_size) begin
            rec_fire           = 1'b1;
            links_done_next    = links_done + 16'd1;
            link_position_next = '0;
          end else begin
            link_position_next = pos_inc[10:0];
          end
        end
      end
    end

    // Verdict: first latched error, else checks on the end position
    if (error_code_next != lsap_pkg::ST_OK) begin
      verdict = error_code_next;
    end else if (fixed_position_next < lsap_pkg::FIXED_PART_BYTES) begin
      verdict = lsap_pkg::ST_SHORT;
    end else if (link_position_next != '0) begin
      verdict = lsap_pkg::ST_TRUNCATED;
    end else if (links_done_next < declared_count_next) begin
      verdict = lsap_pkg::ST_MISSING;
    end else begin
      verdict = lsap_pkg::ST_OK;
    end
  end

  // Result words
  always_comb begin
    push.rec_valid = take && rec_fire;
    push.vrd_valid = take && stg_last;

    rec.kind           = lsap_pkg::KIND_LINK;
    rec.link_index     = links_done;
    rec.link_id        = id_word_next;
    rec.link_info      = data_word_next;
    rec.link_type      = type_byte_next[2:0];
    rec.metric         = metric_acc_next;
    rec.tos_skipped    = tos_entries_next;
    rec.router_flags   = flags_reg_next;
    rec.declared_links = declared_count_next;
    rec.status         = lsap_pkg::ST_OK;
    rec.last_result    = 1'b0;

    vrd.kind           = lsap_pkg::KIND_VERDICT;
    vrd.link_index     = links_done_next;
    vrd.link_id        = '0;
    vrd.link_info      = '0;
    vrd.link_type      = '0;
    vrd.metric         = '0;
    vrd.tos_skipped    = '0;
    vrd.router_flags   = flags_reg_next;
    vrd.declared_links = declared_count_next;
    vrd.status         = verdict;
    vrd.last_result    = 1'b1;
  end

  // State update; the final byte returns everything to reset
  always_ff @(posedge clk) begin
    if (rst || (take && stg_last)) begin
      fixed_position <= '0;
      flags_reg      <= '0;
      declared_count <= '0;
      links_done     <= '0;
      link_position  <= '0;
      tos_entries    <= '0;
      id_word        <= '0;
      data_word      <= '0;
      type_byte      <= '0;
      metric_acc     <= '0;
      error_code     <= lsap_pkg::ST_OK;
    end else if (take) begin
      fixed_position <= fixed_position_next;
      flags_reg      <= flags_reg_next;
      declared_count <= declared_count_next;
      links_done     <= links_done_next;
      link_position  <= link_position_next;
      tos_entries    <= tos_entries_next;
      id_word        <= id_word_next;
      data_word      <= data_word_next;
      type_byte      <= type_byte_next;
      metric_acc     <= metric_acc_next;
      error_code     <= error_code_next;
    end
  end

  // No link record once an error is latched
  a_no_rec_after_error: assert property (@(posedge clk) disable iff (rst)
    push.rec_valid |-> error_code == lsap_pkg::ST_OK)
    else $error("link record emitted after an error was latched");

  // Position within a link never reaches the link length
  a_link_pos_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, link_position} < lsap_pkg::LINK_FIXED_BYTES + {2'b00, tos_entries, 2'b00}))
    else $error("link position past end of link");

  // Fixed-part counter stops at its length
  a_fixed_pos_bound: assert property (@(posedge clk) disable iff (rst)
    fixed_position <= lsap_pkg::FIXED_PART_BYTES)
    else $error("fixed-part position overran");

endmodule

`default_nettype wire

>>> design/lsap_outq.sv
`default_nettype none

// Small result queue: takes up to two results a cycle in order, hands out
// one registered word a cycle while out_ready is high.
module lsap_outq #(
  parameter int unsigned DEPTH = lsap_pkg::OQ_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lsap_pkg::push_t   push,
  input  wire lsap_pkg::result_t rec,
  input  wire lsap_pkg::result_t vrd,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lsap_pkg::result_t      head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  lsap_pkg::result_t mem [DEPTH];
  logic [AW-1:0] rd_ptr, wr_ptr;
  logic [CW-1:0] count;
  logic [CW-1:0] n_push;
  logic          pop;
  logic          any_push;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign any_push  = push.rec_valid || push.vrd_valid;
  assign n_push    = CW'(push.rec_valid) + CW'(push.vrd_valid);
  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign room      = count <= CW'(DEPTH - 2);
  assign head      = mem[rd_ptr];

  // Storage: record first, verdict behind it
  always_ff @(posedge clk) begin
    if (any_push) begin
      mem[wr_ptr] <= push.rec_valid ? rec : vrd;
    end
    if (push.rec_valid && push.vrd_valid) begin
      mem[ptr_inc(wr_ptr)] <= vrd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push.rec_valid && push.vrd_valid) begin
        wr_ptr <= ptr_inc(ptr_inc(wr_ptr));
      end else if (any_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      count <= count + n_push - CW'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    any_push |-> room)
    else $error("result pushed without two free entries");

endmodule

`default_nettype wire

>>> design/ospfv2_router_lsa_link_parser_core.sv
`default_nettype none

// Router-LSA body parser. Takes one body byte per cycle on lsa_bytes and
// returns a link record for each completed link and a verdict word after
// the byte marked last (record first when that byte also ends a link).
// Records are provisional until the verdict reports status 0. A byte is
// registered in an input stage, parsed there, and its results are written
// into a small queue whose head drives results. Throughput is one byte per
// cycle; bytes are held back only while the result queue has fewer than two
// free entries (QUEUE_DEPTH sets its size), which happens only when the
// result side stalls. The queue drains one word per cycle while
// results.ready is high.
module ospfv2_router_lsa_link_parser_core #(
  parameter int unsigned QUEUE_DEPTH = lsap_pkg::OQ_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  lsap_byte_if.sink     lsa_bytes,
  lsap_result_if.source results
);

  lsap_pkg::push_t   push;
  lsap_pkg::result_t rec;
  lsap_pkg::result_t vrd;
  lsap_pkg::result_t head;
  logic              room;

  lsap_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .in_valid (lsa_bytes.valid),
    .in_byte  (lsa_bytes.body_byte),
    .in_last  (lsa_bytes.last),
    .in_ready (lsa_bytes.ready),
    .room     (room),
    .push     (push),
    .rec      (rec),
    .vrd      (vrd)
  );

  lsap_outq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .rec       (rec),
    .vrd       (vrd),
    .room      (room),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .head      (head)
  );

  // Result word onto the channel
  assign results.kind           = head.kind;
  assign results.link_index     = head.link_index;
  assign results.link_id        = head.link_id;
  assign results.link_info      = head.link_info;
  assign results.link_type      = head.link_type;
  assign results.metric         = head.metric;
  assign results.tos_skipped    = head.tos_skipped;
  assign results.router_flags   = head.router_flags;
  assign results.declared_links = head.declared_links;
  assign results.status         = head.status;
  assign results.last_result    = head.last_result;

endmodule

`default_nettype wire

>>> tb/ospfv2_router_lsa_link_parser_core_test.sv
`timescale 1ns / 1ps

module ospfv2_router_lsa_link_parser_core_test;

  localparam int unsigned TOS_ENTRY_BYTES = 4;
  localparam int unsigned ITEM_TARGET     = 650;
  localparam int unsigned HOLD_CYCLES     = 80;
  localparam int unsigned QUIET_LIMIT     = 1000;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned NUM_DIRECTED    = 23;

  // One directed stimulus row; a verdict is typed in where typed is set
  typedef struct packed {
    logic [7:0]  b;
    logic        is_last;
    logic        typed;
    logic [2:0]  st;
    logic [2:0]  flags;
    logic [15:0] decl;
  } stim_row_t;

  logic clk;
  logic rst;

  lsap_byte_if   byte_ch ();
  lsap_result_if res_ch ();

  ospfv2_router_lsa_link_parser_core dut (
    .clk       (clk),
    .rst       (rst),
    .lsa_bytes (byte_ch),
    .results   (res_ch)
  );

  // Parser shadow state
  logic [2:0]  fp_cnt;
  logic [2:0]  flags_r;
  logic [15:0] decl_links;
  logic [15:0] links_seen;
  logic [10:0] link_ofs;
  logic [7:0]  tos_n;
  logic [31:0] lid_w;
  logic [31:0] ldata_w;
  logic [7:0]  ltype_b;
  logic [15:0] metric_w;
  logic [2:0]  err_st;

  lsap_pkg::result_t expected_results [$];
  logic [7:0]        body_q [$];
  stim_row_t         directed_rows [0:NUM_DIRECTED-1];

  int unsigned errors;
  int unsigned words_sent;
  int unsigned useful_items;
  int unsigned lsa_count;
  int unsigned records_checked;
  int unsigned verdict_tally [0:7];

  bit          src_idle_on;
  bit          sink_idle_on;
  int unsigned hold_requests;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_parser();
    fp_cnt     = '0;
    flags_r    = '0;
    decl_links = '0;
    links_seen = '0;
    link_ofs   = '0;
    tos_n      = '0;
    lid_w      = '0;
    ldata_w    = '0;
    ltype_b    = '0;
    metric_w   = '0;
    err_st     = lsap_pkg::ST_OK;
  endfunction

  // Advance the shadow parser by one body byte and queue the results it
  // produces. Returns 1 when the byte was not simply dropped after an error.
  function automatic bit parse_byte(input logic [7:0] b, input logic is_last,
                                    input bit typed, input lsap_pkg::result_t typed_vrd);
    lsap_pkg::result_t r;
    logic [2:0]        st;
    int unsigned       link_len;
    bit                useful;
    useful = (err_st == lsap_pkg::ST_OK) || is_last;
    if (err_st == lsap_pkg::ST_OK) begin
      if (fp_cnt < lsap_pkg::FIXED_PART_BYTES) begin
        case (fp_cnt)
          lsap_pkg::FP_FLAGS:    flags_r = b[2:0];
          lsap_pkg::FP_COUNT_HI: decl_links = {b, 8'h00};
          lsap_pkg::FP_COUNT_LO: decl_links[7:0] = b;
          default: ;
        endcase
        fp_cnt = fp_cnt + 3'd1;
      end else if (links_seen >= decl_links) begin
        err_st = lsap_pkg::ST_TRAILING;
      end else begin
        if (link_ofs < lsap_pkg::LINK_DATA_OFS) begin
          lid_w = {lid_w[23:0], b};
        end else if (link_ofs < lsap_pkg::LINK_TYPE_OFS) begin
          ldata_w = {ldata_w[23:0], b};
        end else if (link_ofs == lsap_pkg::LINK_TYPE_OFS) begin
          ltype_b = b;
          if (b < lsap_pkg::LINK_TYPE_MIN || b > lsap_pkg::LINK_TYPE_MAX)
            err_st = lsap_pkg::ST_BAD_TYPE;
        end else if (link_ofs == lsap_pkg::LINK_TOS_OFS) begin
          tos_n = b;
        end else if (link_ofs < lsap_pkg::LINK_METRIC_END) begin
          metric_w = {metric_w[7:0], b};
        end
        if (err_st == lsap_pkg::ST_OK) begin
          link_len = lsap_pkg::LINK_FIXED_BYTES + TOS_ENTRY_BYTES * tos_n;
          if (link_ofs + 1 >= lsap_pkg::LINK_FIXED_BYTES && link_ofs + 1 >= link_len) begin
            r                = '0;
            r.kind           = lsap_pkg::KIND_LINK;
            r.link_index     = links_seen;
            r.link_id        = lid_w;
            r.link_info      = ldata_w;
            r.link_type      = ltype_b[2:0];
            r.metric         = metric_w;
            r.tos_skipped    = tos_n;
            r.router_flags   = flags_r;
            r.declared_links = decl_links;
            r.status         = lsap_pkg::ST_OK;
            r.last_result    = 1'b0;
            expected_results.push_back(r);
            links_seen = links_seen + 16'd1;
            link_ofs   = '0;
          end else begin
            link_ofs = link_ofs + 11'd1;
          end
        end
      end
    end
    // Verdict closes the LSA and clears everything
    if (is_last) begin
      st = err_st;
      if (st == lsap_pkg::ST_OK) begin
        if (fp_cnt < lsap_pkg::FIXED_PART_BYTES) st = lsap_pkg::ST_SHORT;
        else if (link_ofs != 0)                  st = lsap_pkg::ST_TRUNCATED;
        else if (links_seen < decl_links)        st = lsap_pkg::ST_MISSING;
      end
      r                = '0;
      r.kind           = lsap_pkg::KIND_VERDICT;
      r.link_index     = links_seen;
      r.router_flags   = flags_r;
      r.declared_links = decl_links;
      r.status         = st;
      r.last_result    = 1'b1;
      expected_results.push_back(typed ? typed_vrd : r);
      clear_parser();
    end
    return useful;
  endfunction

  // Offer one body word and wait for it to be taken
  task automatic offer_byte(input logic [7:0] b, input logic is_last,
                            input bit typed, input lsap_pkg::result_t typed_vrd);
    while (src_idle_on && $urandom_range(0, 99) < 34) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.body_byte <= b;
    byte_ch.last      <= is_last;
    do @(posedge clk); while (byte_ch.ready !== 1'b1);
    words_sent++;
    if (parse_byte(b, is_last, typed, typed_vrd)) useful_items++;
  endtask

  // Stop offering and let every expected word come out
  task automatic pause_until_drained();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Random LSA body: mostly well formed, some broken or pure noise
  task automatic build_lsa();
    int unsigned n_links;
    int unsigned tos;
    int unsigned m;
    int unsigned cut;
    int unsigned type_pos [$];
    body_q.delete();
    n_links = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    body_q.push_back(8'($urandom_range(0, 255)));
    body_q.push_back(8'($urandom_range(0, 255)));
    body_q.push_back(8'(n_links >> 8));
    body_q.push_back(8'(n_links));
    for (int k = 0; k < n_links; k++) begin
      repeat (8) body_q.push_back(8'($urandom_range(0, 255)));
      type_pos.push_back(body_q.size());
      body_q.push_back(8'($urandom_range(lsap_pkg::LINK_TYPE_MIN, lsap_pkg::LINK_TYPE_MAX)));
      tos = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      body_q.push_back(8'(tos));
      repeat (2) body_q.push_back(8'($urandom_range(0, 255)));
      repeat (TOS_ENTRY_BYTES * tos) body_q.push_back(8'($urandom_range(0, 255)));
    end
    m = $urandom_range(0, 99);
    if (m < 8 && type_pos.size() != 0) begin
      // illegal link type, below or above the legal range
      body_q[type_pos[$urandom_range(0, type_pos.size() - 1)]] =
        $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(5, 255));
    end else if (m < 16 && body_q.size() > 1) begin
      cut = $urandom_range(1, body_q.size() - 1);
      while (body_q.size() > cut) void'(body_q.pop_back());
    end else if (m < 22) begin
      repeat ($urandom_range(1, 3)) body_q.push_back(8'($urandom_range(0, 255)));
    end else if (m < 27) begin
      body_q[2] = 8'($urandom_range(0, 255));
      body_q[3] = 8'($urandom_range(0, 255));
    end else if (m < 31) begin
      body_q.delete();
      repeat ($urandom_range(1, 24)) body_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Result side: ready pattern, long hold on request, and checking
  initial begin : result_side
    lsap_pkg::result_t want;
    int unsigned       hold_left;
    int unsigned       holds_served;
    res_ch.ready = 1'b0;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: kind %0h status %0h index %0h",
                 res_ch.kind, res_ch.status, res_ch.link_index);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (res_ch.kind !== want.kind) begin
            $error("kind: expected %0h, got %0h", want.kind, res_ch.kind);
            errors++;
          end
          if (res_ch.link_index !== want.link_index) begin
            $error("link_index: expected %0h, got %0h", want.link_index, res_ch.link_index);
            errors++;
          end
          if (res_ch.link_id !== want.link_id) begin
            $error("link_id: expected %0h, got %0h", want.link_id, res_ch.link_id);
            errors++;
          end
          if (res_ch.link_info !== want.link_info) begin
            $error("link_info: expected %0h, got %0h", want.link_info, res_ch.link_info);
            errors++;
          end
          if (res_ch.link_type !== want.link_type) begin
            $error("link_type: expected %0h, got %0h", want.link_type, res_ch.link_type);
            errors++;
          end
          if (res_ch.metric !== want.metric) begin
            $error("metric: expected %0h, got %0h", want.metric, res_ch.metric);
            errors++;
          end
          if (res_ch.tos_skipped !== want.tos_skipped) begin
            $error("tos_skipped: expected %0h, got %0h", want.tos_skipped,
                   res_ch.tos_skipped);
            errors++;
          end
          if (res_ch.router_flags !== want.router_flags) begin
            $error("router_flags: expected %0h, got %0h", want.router_flags,
                   res_ch.router_flags);
            errors++;
          end
          if (res_ch.declared_links !== want.declared_links) begin
            $error("declared_links: expected %0h, got %0h", want.declared_links,
                   res_ch.declared_links);
            errors++;
          end
          if (res_ch.status !== want.status) begin
            $error("status: expected %0h, got %0h", want.status, res_ch.status);
            errors++;
          end
          if (res_ch.last_result !== want.last_result) begin
            $error("last_result: expected %0h, got %0h", want.last_result,
                   res_ch.last_result);
            errors++;
          end
          if (want.kind == lsap_pkg::KIND_LINK) records_checked++;
          else verdict_tally[want.status]++;
        end
      end
      // next ready value
      if (hold_left != 0) begin
        res_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (holds_served != hold_requests) begin
        res_ch.ready <= 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        holds_served = hold_requests;
      end else if (sink_idle_on && $urandom_range(0, 99) < 34) begin
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any word moving on either side
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    lsap_pkg::result_t vrd;
    stim_row_t         row;
    int unsigned       lsa_no;
    bit                quiet;
    rst               = 1'b1;
    byte_ch.valid     = 1'b0;
    byte_ch.body_byte = '0;
    byte_ch.last      = 1'b0;
    src_idle_on       = 1'b1;
    sink_idle_on      = 1'b1;
    hold_requests     = 0;
    errors            = 0;
    words_sent        = 0;
    useful_items      = 0;
    lsa_count         = 0;
    records_checked   = 0;
    foreach (verdict_tally[i]) verdict_tally[i] = 0;
    clear_parser();

    directed_rows = '{
      // short body right after reset, all-ones byte
      '{8'hFF, 1'b1, 1'b1, lsap_pkg::ST_SHORT,    3'd7, 16'h0000},
      // largest link count, body ends at the boundary
      '{8'h02, 1'b0, 1'b0, lsap_pkg::ST_OK,       3'd0, 16'h0000},
      '{8'h00, 1'b0, 1'b0, lsap_pkg::ST_OK,       3'd0, 16'h0000},
      '{8'hFF, 1'b0, 1'b0, lsap_pkg::ST_OK,       3'd0, 16'h0000},
      '{8'hFF, 1'b1, 1'b1, lsap_pkg::ST_MISSING,  3'd2, 16'hFFFF},
      // no links declared, one byte too many
      '{8'h05, 1'b0, 1'b0, lsap_pkg::ST_OK,       3'd0, 16'h0000},
      '{8'hFF, 1'b0, 1'b0, lsap_pkg::ST_OK,       3'd0, 16'h0000},
      '{8'h00, 1'b0, 1'b0, lsap_pkg::ST_OK,       3'd0, 16'h0000},
      '{8'h00, 1'b0, 1'b0, lsap_pkg::ST_OK,       3'd0, 16'h0000},
      '{8'hAA, 1'b1, 1'b1, lsap_pkg::ST_TRAILING, 3'd5, 16'h0000},
      // two links declared, first has type above the legal range
      '{8'hF8, 1'b0, 1'b0, lsap_pkg::ST_OK,       3'd0, 16'h0000},
      '{8'h00, 1'b0, 1'b0, lsap_pkg::ST_OK,       3'd0, 16'h0000},
      '{8'h00, 1'b0, 1'b0, lsap_pkg::ST_OK,       3'd0, 16'h0000},
      '{8'h02, 1'b0, 1'b0, lsap_pkg::ST_OK,       3'd0, 16'h0000},
      '{8'hFF, 1'b0, 1'b0, lsap_pkg::ST_OK,       3'd0, 16'h0000},
      '{8'hFF, 1'b0, 1'b0, lsap_pkg::ST_OK,       3'd0, 16'h0000},
      '{8'hFF, 1'b0, 1'b0, lsap_pkg::ST_OK,       3'd0, 16'h0000},
      '{8'hFF, 1'b0, 1'b0, lsap_pkg::ST_OK,       3'd0, 16'h0000},
      '{8'h00, 1'b0, 1'b0, lsap_pkg::ST_OK,       3'd0, 16'h0000},
      '{8'h00, 1'b0, 1'b0, lsap_pkg::ST_OK,       3'd0, 16'h0000},
      '{8'h00, 1'b0, 1'b0, lsap_pkg::ST_OK,       3'd0, 16'h0000},
      '{8'h00, 1'b0, 1'b0, lsap_pkg::ST_OK,       3'd0, 16'h0000},
      '{8'h05, 1'b1, 1'b1, lsap_pkg::ST_BAD_TYPE, 3'd0, 16'h0002}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row                = directed_rows[i];
      vrd                = '0;
      vrd.kind           = lsap_pkg::KIND_VERDICT;
      vrd.router_flags   = row.flags;
      vrd.declared_links = row.decl;
      vrd.status         = row.st;
      vrd.last_result    = 1'b1;
      offer_byte(row.b, row.is_last, row.typed, vrd);
      if (row.is_last) lsa_count++;
    end
    pause_until_drained();

    // Random LSAs; a quiet stretch with no idling carries the long hold
    lsa_no = 0;
    while (words_sent < ITEM_TARGET) begin
      quiet = (lsa_no >= 3 && lsa_no < 7);
      src_idle_on  = !quiet;
      sink_idle_on <= !quiet;
      if (lsa_no == 4) hold_requests <= hold_requests + 1;
      if (lsa_no % 4 == 3) pause_until_drained();
      build_lsa();
      for (int i = 0; i < body_q.size(); i++)
        offer_byte(body_q[i], i == body_q.size() - 1, 1'b0, '0);
      lsa_count++;
      lsa_no++;
    end

    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected result words never arrived", expected_results.size());
      errors++;
    end

    $display("Run covered %0d LSA bodies, %0d body words (%0d parsed), %0d link records",
             lsa_count, words_sent, useful_items, records_checked);
    $display("Verdicts: ok %0d, short %0d, bad type %0d, truncated %0d, missing %0d, %s %0d",
             verdict_tally[lsap_pkg::ST_OK], verdict_tally[lsap_pkg::ST_SHORT],
             verdict_tally[lsap_pkg::ST_BAD_TYPE], verdict_tally[lsap_pkg::ST_TRUNCATED],
             verdict_tally[lsap_pkg::ST_MISSING], "trailing",
             verdict_tally[lsap_pkg::ST_TRAILING]);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
